[src/irlc_pkg.sv]
// irlc_pkg: shared types, constants and tables for the ir remote led strip block
// depends on nothing; used by every module under src by scoped names

package irlc_pkg;

  // strip geometry
  localparam int LED_COUNT = 31;
  localparam logic [4:0] LED_LAST = 5'(LED_COUNT - 1);

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // remote command codes
  localparam logic [15:0] CODE_BRI_UP    = 16'hA35C;
  localparam logic [15:0] CODE_BRI_DOWN  = 16'hA25D;
  localparam logic [15:0] CODE_RED_UP    = 16'hEB14;
  localparam logic [15:0] CODE_RED_DOWN  = 16'hEF10;
  localparam logic [15:0] CODE_GRN_UP    = 16'hEA15;
  localparam logic [15:0] CODE_GRN_DOWN  = 16'hEE11;
  localparam logic [15:0] CODE_BLU_UP    = 16'hE916;
  localparam logic [15:0] CODE_BLU_DOWN  = 16'hED12;
  localparam logic [15:0] CODE_SALMON    = 16'hAB54;
  localparam logic [15:0] CODE_DARK_ORNG = 16'hAF50;
  localparam logic [15:0] CODE_ORANGE    = 16'hE31C;
  localparam logic [15:0] CODE_YELLOW    = 16'hE718;
  localparam logic [15:0] CODE_CYAN_A    = 16'hE41B;
  localparam logic [15:0] CODE_CYAN_B    = 16'hE01F;
  localparam logic [15:0] CODE_RED       = 16'hA758;
  localparam logic [15:0] CODE_GREEN     = 16'hA659;
  localparam logic [15:0] CODE_BLUE      = 16'hBA45;
  localparam logic [15:0] CODE_WHITE     = 16'hBB44;
  localparam logic [15:0] CODE_MAGENTA_A = 16'hB748;
  localparam logic [15:0] CODE_MAGENTA_B = 16'hB34C;
  localparam logic [15:0] CODE_PARTY     = 16'hF30C;

  localparam logic [2:0] BRI_TOP = 3'b111;
  localparam logic [7:0] BRI_RESET = 8'hFF;
  localparam logic [63:0] PI_Q28 = 64'd843314857;

  // three wave bytes for one phase
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } wave_t;

  // one job handed from front to back
  typedef struct packed {
    logic       party;
    logic       gradient;
    wave_t      wave;
    logic [7:0] party_bri;
    logic       solid;
    logic [7:0] solid_bri;
    logic [7:0] solid_red;
    logic [7:0] solid_green;
    logic [7:0] solid_blue;
  } job_t;

  // back end segment state
  typedef enum logic [1:0] {
    SEG_START,
    SEG_PARTY,
    SEG_SOLID
  } seg_t;

  // |cos| table over a folded quarter wave, index 0..768 used
  typedef logic [7:0] wave_tab_t [0:1023];
  typedef logic [7:0] grad_tab_t [0:31];

  function automatic wave_tab_t build_wave_tab();
    wave_tab_t t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint sum;
    int q;
    int k;
    for (q = 0; q < 1024; q++) begin
      if (q > 768) begin
        t[q] = 8'd0;
      end else begin
        x = (PI_Q28 * 64'(q)) / 64'd1536;
        x2 = (x * x) >> 28;
        term = 64'd1 << 28;
        sum = longint'(term);
        for (k = 1; k <= 8; k++) begin
          term = ((term * x2) >> 28) / 64'((2 * k - 1) * (2 * k));
          if ((k % 2) == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum <= 0) begin
          t[q] = 8'd0;
        end else begin
          v = (64'(sum) * 64'd255) >> 28;
          t[q] = (v > 64'd255) ? 8'd255 : v[7:0];
        end
      end
    end
    return t;
  endfunction

  function automatic grad_tab_t build_grad_tab();
    grad_tab_t t;
    int i;
    for (i = 0; i < 32; i++) begin
      if (i < LED_COUNT) t[i] = 8'((i * 255) / LED_COUNT);
      else t[i] = 8'd0;
    end
    return t;
  endfunction

  localparam wave_tab_t WAVE_TAB = build_wave_tab();
  localparam grad_tab_t GRAD_TAB = build_grad_tab();

endpackage

[src/irlc_wave.sv]
// irlc_wave: computes the three |cos| wave bytes for one phase, one channel a cycle
// depends on irlc_pkg (wave table, wave_t)

module irlc_wave (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [9:0]         phase,
  output logic               wave_ok,
  output irlc_pkg::wave_t    wave
);

  logic        busy_r, busy_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [9:0]  phase_r, phase_nxt;
  logic        idx_vld_r, idx_vld_nxt;
  logic [1:0]  idx_ch_r, idx_ch_nxt;
  logic [9:0]  idx_r, idx_nxt;
  logic        ok_r, ok_nxt;
  irlc_pkg::wave_t wave_r, wave_nxt;

  logic [12:0] p_raw;
  logic [11:0] p_3072;
  logic [10:0] p_1536;
  logic [10:0] p_fold;
  logic [7:0]  tab_val;

  // fold phase index into the quarter wave
  always_comb begin
    p_raw  = 13'(3 * phase_r) + {1'b0, ch_r, 10'd0};
    p_3072 = (p_raw >= 13'd3072) ? 12'(p_raw - 13'd3072) : p_raw[11:0];
    p_1536 = (p_3072 >= 12'd1536) ? 11'(p_3072 - 12'd1536) : p_3072[10:0];
    p_fold = (p_1536 > 11'd768) ? 11'(11'd1536 - p_1536) : p_1536;
  end

  assign tab_val = irlc_pkg::WAVE_TAB[idx_r];

  // channel sequencer and registered table read
  always_comb begin
    busy_nxt    = busy_r;
    ch_nxt      = ch_r;
    phase_nxt   = phase_r;
    idx_vld_nxt = 1'b0;
    idx_ch_nxt  = idx_ch_r;
    idx_nxt     = idx_r;
    ok_nxt      = ok_r;
    wave_nxt    = wave_r;
    if (start) begin
      busy_nxt  = 1'b1;
      ch_nxt    = 2'd0;
      phase_nxt = phase;
      ok_nxt    = 1'b0;
    end else if (busy_r) begin
      idx_vld_nxt = 1'b1;
      idx_ch_nxt  = ch_r;
      idx_nxt     = p_fold[9:0];
      ch_nxt      = 2'(ch_r + 2'd1);
      if (ch_r == 2'd2) busy_nxt = 1'b0;
    end
    if (idx_vld_r && !start) begin
      case (idx_ch_r)
        2'd0: wave_nxt.red = tab_val;
        2'd1: wave_nxt.green = tab_val;
        2'd2: begin
          wave_nxt.blue = tab_val;
          ok_nxt = 1'b1;
        end
        default: wave_nxt = wave_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      ch_r      <= 2'd0;
      idx_vld_r <= 1'b0;
      ok_r      <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      ch_r      <= ch_nxt;
      idx_vld_r <= idx_vld_nxt;
      ok_r      <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    idx_ch_r <= idx_ch_nxt;
    idx_r    <= idx_nxt;
    wave_r   <= wave_nxt;
  end

  assign wave_ok = ok_r;
  assign wave    = wave_r;

endmodule

[src/irlc_front.sv]
// irlc_front: accepts items, decodes remote codes, keeps mode and colour state, builds jobs
// depends on irlc_pkg and irlc_wave

module irlc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [15:0]        in_ir_code,
  input  logic               q_full,
  output logic               q_push,
  output irlc_pkg::job_t     q_job
);

  logic       party_r, party_nxt;
  logic       grad_r, grad_nxt;
  logic [9:0] phase_r, phase_nxt;
  logic [7:0] sbri_r, sbri_nxt;
  logic [7:0] sred_r, sred_nxt;
  logic [7:0] sgrn_r, sgrn_nxt;
  logic [7:0] sblu_r, sblu_nxt;
  logic [7:0] strip_bri_r, strip_bri_nxt;
  logic       kick_r, kick_nxt;

  logic            acc;
  logic            refresh;
  logic            clear_party;
  logic            wave_ok;
  irlc_pkg::wave_t wave;

  function automatic logic [7:0] step_up(input logic [7:0] c);
    return 8'(c + {3'd0, 5'(5'd16 - {1'b0, c[3:0]})});
  endfunction

  function automatic logic [7:0] step_down(input logic [7:0] c);
    return 8'(c - {3'd0, 5'(5'd16 - {1'b0, c[3:0]})});
  endfunction

  irlc_wave u_wave (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (kick_r),
    .phase   (phase_r),
    .wave_ok (wave_ok),
    .wave    (wave)
  );

  // a party item waits for the wave bytes of the current phase
  assign in_ready = !q_full && !kick_r && (!party_r || wave_ok);
  assign acc      = in_valid && in_ready;

  // code decode and state update
  always_comb begin
    party_nxt     = party_r;
    grad_nxt      = grad_r;
    phase_nxt     = phase_r;
    sbri_nxt      = sbri_r;
    sred_nxt      = sred_r;
    sgrn_nxt      = sgrn_r;
    sblu_nxt      = sblu_r;
    strip_bri_nxt = strip_bri_r;
    kick_nxt      = 1'b0;
    refresh       = 1'b0;
    clear_party   = 1'b0;
    if (acc) begin
      if (party_r) begin
        phase_nxt = 10'(phase_r + 10'd1);
        kick_nxt  = 1'b1;
      end
      if (in_operation) begin
        refresh     = 1'b1;
        clear_party = 1'b1;
        case (in_ir_code)
          irlc_pkg::CODE_BRI_UP: begin
            sbri_nxt    = {irlc_pkg::BRI_TOP, 5'(sbri_r[4:0] + 5'd1)};
            clear_party = 1'b0;
          end
          irlc_pkg::CODE_BRI_DOWN: begin
            sbri_nxt    = {irlc_pkg::BRI_TOP, 5'(sbri_r[4:0] - 5'd1)};
            clear_party = 1'b0;
          end
          irlc_pkg::CODE_RED_UP:    sred_nxt = step_up(sred_r);
          irlc_pkg::CODE_RED_DOWN:  sred_nxt = step_down(sred_r);
          irlc_pkg::CODE_GRN_UP:    sgrn_nxt = step_up(sgrn_r);
          irlc_pkg::CODE_GRN_DOWN:  sgrn_nxt = step_down(sgrn_r);
          irlc_pkg::CODE_BLU_UP:    sblu_nxt = step_up(sblu_r);
          irlc_pkg::CODE_BLU_DOWN:  sblu_nxt = step_down(sblu_r);
          irlc_pkg::CODE_SALMON: begin
            sred_nxt = 8'd250; sgrn_nxt = 8'd128; sblu_nxt = 8'd114;
          end
          irlc_pkg::CODE_DARK_ORNG: begin
            sred_nxt = 8'd255; sgrn_nxt = 8'd140; sblu_nxt = 8'd0;
          end
          irlc_pkg::CODE_ORANGE: begin
            sred_nxt = 8'd255; sgrn_nxt = 8'd165; sblu_nxt = 8'd0;
          end
          irlc_pkg::CODE_YELLOW: begin
            sred_nxt = 8'd255; sgrn_nxt = 8'd255; sblu_nxt = 8'd0;
          end
          irlc_pkg::CODE_CYAN_A, irlc_pkg::CODE_CYAN_B: begin
            sred_nxt = 8'd0; sgrn_nxt = 8'd255; sblu_nxt = 8'd255;
          end
          irlc_pkg::CODE_RED: begin
            sred_nxt = 8'd255; sgrn_nxt = 8'd0; sblu_nxt = 8'd0;
          end
          irlc_pkg::CODE_GREEN: begin
            sred_nxt = 8'd0; sgrn_nxt = 8'd255; sblu_nxt = 8'd0;
          end
          irlc_pkg::CODE_BLUE: begin
            sred_nxt = 8'd0; sgrn_nxt = 8'd0; sblu_nxt = 8'd255;
          end
          irlc_pkg::CODE_WHITE: begin
            sred_nxt = 8'd255; sgrn_nxt = 8'd255; sblu_nxt = 8'd255;
          end
          irlc_pkg::CODE_MAGENTA_A, irlc_pkg::CODE_MAGENTA_B: begin
            sred_nxt = 8'd255; sgrn_nxt = 8'd0; sblu_nxt = 8'd255;
          end
          irlc_pkg::CODE_PARTY: begin
            party_nxt   = 1'b1;
            grad_nxt    = !grad_r;
            clear_party = 1'b0;
            refresh     = 1'b0;
          end
          default: clear_party = 1'b1;
        endcase
        if (clear_party) party_nxt = 1'b0;
        if (refresh) strip_bri_nxt = sbri_nxt;
      end
    end
  end

  // job for the back end: party part from old state, solid part from new
  always_comb begin
    q_push            = acc && (party_r || refresh);
    q_job.party       = party_r;
    q_job.gradient    = grad_r;
    q_job.wave        = wave;
    q_job.party_bri   = strip_bri_r;
    q_job.solid       = refresh;
    q_job.solid_bri   = sbri_nxt;
    q_job.solid_red   = sred_nxt;
    q_job.solid_green = sgrn_nxt;
    q_job.solid_blue  = sblu_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      party_r     <= 1'b0;
      grad_r      <= 1'b0;
      phase_r     <= 10'd0;
      sbri_r      <= irlc_pkg::BRI_RESET;
      sred_r      <= 8'd0;
      sgrn_r      <= 8'd0;
      sblu_r      <= 8'd0;
      strip_bri_r <= irlc_pkg::BRI_RESET;
      kick_r      <= 1'b1;
    end else begin
      party_r     <= party_nxt;
      grad_r      <= grad_nxt;
      phase_r     <= phase_nxt;
      sbri_r      <= sbri_nxt;
      sred_r      <= sred_nxt;
      sgrn_r      <= sgrn_nxt;
      sblu_r      <= sblu_nxt;
      strip_bri_r <= strip_bri_nxt;
      kick_r      <= kick_nxt;
    end
  end

endmodule

[src/irlc_queue.sv]
// irlc_queue: short show-ahead job queue between front and back
// depends on irlc_pkg (job_t, QDEPTH)

module irlc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  irlc_pkg::job_t     push_job,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output irlc_pkg::job_t     head
);

  irlc_pkg::job_t                 mem_r [0:irlc_pkg::QDEPTH-1];
  logic [irlc_pkg::QAW-1:0]       wptr_r, wptr_nxt;
  logic [irlc_pkg::QAW-1:0]       rptr_r, rptr_nxt;
  logic [irlc_pkg::QAW:0]         cnt_r, cnt_nxt;

  assign full  = (cnt_r == (irlc_pkg::QAW+1)'(irlc_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  // pointer and fill count
  always_comb begin
    wptr_nxt = push ? (irlc_pkg::QAW)'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = pop ? (irlc_pkg::QAW)'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) cnt_nxt = (irlc_pkg::QAW+1)'(cnt_r + 1'b1);
    else if (pop && !push) cnt_nxt = (irlc_pkg::QAW+1)'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_job;
  end

endmodule

[src/irlc_back.sv]
// irlc_back: walks the head job, one led frame per cycle while the output is not stalled, into the output register
// depends on irlc_pkg (job_t, seg_t, gradient table)

module irlc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  irlc_pkg::job_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_led_index,
  output logic [7:0]         out_frame_brightness,
  output logic [7:0]         out_frame_red,
  output logic [7:0]         out_frame_green,
  output logic [7:0]         out_frame_blue,
  output logic               out_end_of_strip,
  output logic               out_last
);

  irlc_pkg::seg_t seg_r, seg_nxt;
  logic [4:0]     idx_r, idx_nxt;
  logic           ov_r, ov_nxt;
  logic [4:0]     o_idx_r;
  logic [7:0]     o_bri_r, o_red_r, o_grn_r, o_blu_r;
  logic           o_eos_r, o_last_r;

  logic           adv;
  logic           emit;
  logic           in_party;
  logic           last_led;
  logic           job_end;
  logic [7:0]     f_bri, f_red, f_grn, f_blu;

  assign adv = !ov_r || out_ready;

  // frame content for the current led
  always_comb begin
    case (seg_r)
      irlc_pkg::SEG_PARTY: in_party = 1'b1;
      irlc_pkg::SEG_SOLID: in_party = 1'b0;
      default:             in_party = q_head.party;
    endcase
    emit     = adv && !q_empty;
    last_led = (idx_r == irlc_pkg::LED_LAST);
    job_end  = last_led && (!in_party || !q_head.solid);
    q_pop    = emit && job_end;
    if (in_party) begin
      f_bri = q_head.party_bri;
      f_red = q_head.gradient ? irlc_pkg::GRAD_TAB[idx_r] : q_head.wave.red;
      f_grn = q_head.wave.green;
      f_blu = q_head.wave.blue;
    end else begin
      f_bri = q_head.solid_bri;
      f_red = q_head.solid_red;
      f_grn = q_head.solid_green;
      f_blu = q_head.solid_blue;
    end
  end

  // segment sequencing
  always_comb begin
    seg_nxt = seg_r;
    idx_nxt = idx_r;
    ov_nxt  = ov_r;
    if (adv) ov_nxt = emit;
    if (emit) begin
      if (last_led) begin
        idx_nxt = 5'd0;
        seg_nxt = job_end ? irlc_pkg::SEG_START : irlc_pkg::SEG_SOLID;
      end else begin
        idx_nxt = 5'(idx_r + 5'd1);
        seg_nxt = in_party ? irlc_pkg::SEG_PARTY : irlc_pkg::SEG_SOLID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= irlc_pkg::SEG_START;
      idx_r <= 5'd0;
      ov_r  <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      o_idx_r  <= idx_r;
      o_bri_r  <= f_bri;
      o_red_r  <= f_red;
      o_grn_r  <= f_grn;
      o_blu_r  <= f_blu;
      o_eos_r  <= last_led;
      o_last_r <= job_end;
    end
  end

  assign out_valid            = ov_r;
  assign out_led_index        = o_idx_r;
  assign out_frame_brightness = o_bri_r;
  assign out_frame_red        = o_red_r;
  assign out_frame_green      = o_grn_r;
  assign out_frame_blue       = o_blu_r;
  assign out_end_of_strip     = o_eos_r;
  assign out_last             = o_last_r;

endmodule

[src/ir_remote_led_strip_color_control.sv]
// ir_remote_led_strip_color_control: top level, front decoder, job queue and frame back end
// an accepted item's job goes through the queue to the back end, which registers each frame
// throughput: one led frame per cycle while the output is not stalled; an item yields 31 frames
// per strip refresh it causes, 62 with a party and a solid refresh, none with neither; in party
// mode each accepted item holds off the next while the three wave bytes are looked up, hidden by the queue
// reset: synchronous active low rst_n clears modes, phase, colours and the queue
// depends on irlc_pkg, irlc_front, irlc_queue, irlc_back

module ir_remote_led_strip_color_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_ir_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_led_index,
  output logic [7:0]  out_frame_brightness,
  output logic [7:0]  out_frame_red,
  output logic [7:0]  out_frame_green,
  output logic [7:0]  out_frame_blue,
  output logic        out_end_of_strip,
  output logic        out_last
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  irlc_pkg::job_t q_job;
  irlc_pkg::job_t q_head;

  // decode and state
  irlc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_ir_code   (in_ir_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // job queue
  irlc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // frame generation
  irlc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_led_index        (out_led_index),
    .out_frame_brightness (out_frame_brightness),
    .out_frame_red        (out_frame_red),
    .out_frame_green      (out_frame_green),
    .out_frame_blue       (out_frame_blue),
    .out_end_of_strip     (out_end_of_strip),
    .out_last             (out_last)
  );

endmodule

[bench/tb_ir_remote_led_strip_color_control.sv]
// tb_ir_remote_led_strip_color_control: self-checking bench for the ir remote led strip block
// predicts every led frame from the decoded remote codes and compares in order
// depends on irlc_pkg and ir_remote_led_strip_color_control under src
`timescale 1ns / 100ps

module tb_ir_remote_led_strip_color_control;
  import irlc_pkg::*;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_CODE = 1'b1
  } op_e;

  // one led frame as seen on the result channel
  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] bri;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eos;
    logic       fin;
  } frame_t;

  localparam int STALL_CYCLES = 400;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = 1'b0;
  logic [15:0] in_ir_code = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_led_index;
  logic [7:0]  out_frame_brightness;
  logic [7:0]  out_frame_red;
  logic [7:0]  out_frame_green;
  logic [7:0]  out_frame_blue;
  logic        out_end_of_strip;
  logic        out_last;

  // predictor state
  logic       party_on;
  logic       grad_on;
  logic [9:0] phase;
  logic [7:0] sol_bri;
  logic [7:0] sol_r;
  logic [7:0] sol_g;
  logic [7:0] sol_b;
  logic [7:0] strip_bri;

  frame_t frames_due[$];

  int  errors = 0;
  int  items_sent = 0;
  int  frames_seen = 0;
  int  party_frames = 0;
  bit  calm = 1'b0;
  bit  stall_req = 1'b0;
  int  stall_left = 0;

  ir_remote_led_strip_color_control dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_ir_code           (in_ir_code),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_led_index        (out_led_index),
    .out_frame_brightness (out_frame_brightness),
    .out_frame_red        (out_frame_red),
    .out_frame_green      (out_frame_green),
    .out_frame_blue       (out_frame_blue),
    .out_end_of_strip     (out_end_of_strip),
    .out_last             (out_last)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // |cos| magnitude scaled to 0..255, computed in q28 fixed point, phase taken mod 3072
  function automatic logic [7:0] cos_mag(int unsigned p);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      acc;
    int unsigned q;
    int          k;
    q = (p % 3072) % 1536;
    if (q > 768) q = 1536 - q;
    x = (PI_Q28 * 64'(q)) / 64'd1536;
    x2 = (x * x) >> 28;
    term = 64'd1 << 28;
    acc = longint'(term);
    for (k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 28) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc <= 0) return 8'd0;
    v = (64'(acc) * 64'd255) >> 28;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic frame_t make_frame(int i, logic [7:0] b, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] bl);
    frame_t f;
    f.idx = 5'(i);
    f.bri = b;
    f.red = r;
    f.green = g;
    f.blue = bl;
    f.eos = (i == LED_COUNT - 1);
    f.fin = 1'b0;
    return f;
  endfunction

  function automatic logic [7:0] step_up(logic [7:0] c);
    return 8'(c + (8'd16 - (c % 8'd16)));
  endfunction

  function automatic logic [7:0] step_down(logic [7:0] c);
    return 8'(c - (8'd16 - (c % 8'd16)));
  endfunction

  // works out the frames of one service call and queues them
  function automatic void predict_frames(logic op, logic [15:0] code);
    frame_t      batch [0:61];
    int          n;
    int          i;
    logic        refresh;
    logic        clear;
    int unsigned base;
    logic [7:0]  r;
    n = 0;
    refresh = 1'b0;
    clear = 1'b1;

    // party refresh first, then the phase steps
    if (party_on) begin
      base = 3 * int'(phase);
      for (i = 0; i < LED_COUNT; i++) begin
        r = grad_on ? 8'((i * 255) / LED_COUNT) : cos_mag(base);
        batch[n] = make_frame(i, strip_bri, r, cos_mag(base + 1024), cos_mag(base + 2048));
        n++;
      end
      party_frames += LED_COUNT;
      phase = phase + 10'd1;
    end

    // decode the remote code
    if (op == OP_CODE) begin
      refresh = 1'b1;
      case (code)
        CODE_BRI_UP: begin
          sol_bri = {BRI_TOP, 5'(sol_bri[4:0] + 5'd1)};
          clear = 1'b0;
        end
        CODE_BRI_DOWN: begin
          sol_bri = {BRI_TOP, 5'(sol_bri[4:0] - 5'd1)};
          clear = 1'b0;
        end
        CODE_RED_UP:    sol_r = step_up(sol_r);
        CODE_RED_DOWN:  sol_r = step_down(sol_r);
        CODE_GRN_UP:    sol_g = step_up(sol_g);
        CODE_GRN_DOWN:  sol_g = step_down(sol_g);
        CODE_BLU_UP:    sol_b = step_up(sol_b);
        CODE_BLU_DOWN:  sol_b = step_down(sol_b);
        CODE_SALMON:    {sol_r, sol_g, sol_b} = {8'd250, 8'd128, 8'd114};
        CODE_DARK_ORNG: {sol_r, sol_g, sol_b} = {8'd255, 8'd140, 8'd0};
        CODE_ORANGE:    {sol_r, sol_g, sol_b} = {8'd255, 8'd165, 8'd0};
        CODE_YELLOW:    {sol_r, sol_g, sol_b} = {8'd255, 8'd255, 8'd0};
        CODE_CYAN_A,
        CODE_CYAN_B:    {sol_r, sol_g, sol_b} = {8'd0, 8'd255, 8'd255};
        CODE_RED:       {sol_r, sol_g, sol_b} = {8'd255, 8'd0, 8'd0};
        CODE_GREEN:     {sol_r, sol_g, sol_b} = {8'd0, 8'd255, 8'd0};
        CODE_BLUE:      {sol_r, sol_g, sol_b} = {8'd0, 8'd0, 8'd255};
        CODE_WHITE:     {sol_r, sol_g, sol_b} = {8'd255, 8'd255, 8'd255};
        CODE_MAGENTA_A,
        CODE_MAGENTA_B: {sol_r, sol_g, sol_b} = {8'd255, 8'd0, 8'd255};
        CODE_PARTY: begin
          party_on = 1'b1;
          grad_on = ~grad_on;
          clear = 1'b0;
          refresh = 1'b0;
        end
        default: ;
      endcase
      if (refresh && clear) party_on = 1'b0;
    end

    // solid refresh of the whole strip
    if (refresh) begin
      for (i = 0; i < LED_COUNT; i++) begin
        batch[n] = make_frame(i, sol_bri, sol_r, sol_g, sol_b);
        n++;
      end
      strip_bri = sol_bri;
    end

    if (n > 0) batch[n - 1].fin = 1'b1;
    for (i = 0; i < n; i++) frames_due.push_back(batch[i]);
  endfunction

  // sends one item, idling first at random; returns at a falling edge
  task automatic send_item(op_e op, logic [15:0] code);
    int gap;
    if (!calm && $urandom_range(0, 99) < 34) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_ir_code <= code;
    do @(posedge clk); while (!in_ready);
    predict_frames(op, code);
    items_sent++;
    @(negedge clk);
  endtask

  // result side: random ready, plus the long hold-off on request
  always @(negedge clk) begin
    if (stall_req) begin
      stall_left = STALL_CYCLES;
      stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 34);
    end
  end

  task automatic cmp_field(string what, int e, int a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, e, a);
    end
  endtask

  // compare every accepted frame with the oldest prediction
  always @(posedge clk) begin
    frame_t f;
    if (rst_n && out_valid && out_ready) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame, expected none, actual led %0d", $time,
                 out_led_index);
      end else begin
        f = frames_due.pop_front();
        cmp_field("led_index", f.idx, out_led_index);
        cmp_field("frame_brightness", f.bri, out_frame_brightness);
        cmp_field("frame_red", f.red, out_frame_red);
        cmp_field("frame_green", f.green, out_frame_green);
        cmp_field("frame_blue", f.blue, out_frame_blue);
        cmp_field("end_of_strip", f.eos, out_end_of_strip);
        cmp_field("last", f.fin, out_last);
      end
    end
  end

  // picks a code, mostly meaningful ones
  function automatic logic [15:0] pick_code();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return CODE_PARTY;
    if (sel < 20) return ($urandom_range(0, 1) != 0) ? CODE_BRI_UP : CODE_BRI_DOWN;
    if (sel < 50) begin
      case ($urandom_range(0, 5))
        0: return CODE_RED_UP;
        1: return CODE_RED_DOWN;
        2: return CODE_GRN_UP;
        3: return CODE_GRN_DOWN;
        4: return CODE_BLU_UP;
        default: return CODE_BLU_DOWN;
      endcase
    end
    if (sel < 72) begin
      case ($urandom_range(0, 13))
        0: return CODE_SALMON;
        1: return CODE_DARK_ORNG;
        2: return CODE_ORANGE;
        3: return CODE_YELLOW;
        4: return CODE_CYAN_A;
        5: return CODE_CYAN_B;
        6: return CODE_RED;
        7: return CODE_GREEN;
        8: return CODE_BLUE;
        9: return CODE_WHITE;
        10: return CODE_MAGENTA_A;
        11: return CODE_MAGENTA_B;
        12: return CODE_PARTY;
        default: return CODE_SALMON;
      endcase
    end
    return 16'($urandom());
  endfunction

  task automatic test_idle_calls();
    send_item(OP_TICK, 16'hFFFF);
    send_item(OP_TICK, 16'h0000);
  endtask

  task automatic test_brightness_wrap();
    send_item(OP_CODE, CODE_BRI_UP);
    send_item(OP_CODE, CODE_BRI_DOWN);
  endtask

  task automatic test_color_steps();
    send_item(OP_CODE, CODE_RED_DOWN);
    send_item(OP_CODE, CODE_RED_UP);
    send_item(OP_CODE, CODE_GRN_UP);
    send_item(OP_CODE, CODE_GRN_DOWN);
    send_item(OP_CODE, CODE_BLU_UP);
    send_item(OP_CODE, CODE_BLU_DOWN);
  endtask

  task automatic test_presets();
    send_item(OP_CODE, CODE_SALMON);
    send_item(OP_CODE, CODE_WHITE);
    send_item(OP_CODE, CODE_MAGENTA_B);
    send_item(OP_CODE, CODE_CYAN_A);
  endtask

  task automatic test_unknown_codes();
    send_item(OP_CODE, 16'h0000);
    send_item(OP_CODE, 16'hFFFF);
  endtask

  // gradient on, brightness inside party, gradient off, then a step clears party
  task automatic test_party_modes();
    send_item(OP_CODE, CODE_PARTY);
    send_item(OP_TICK, 16'h5A5A);
    send_item(OP_CODE, CODE_BRI_DOWN);
    send_item(OP_CODE, CODE_PARTY);
    send_item(OP_TICK, 16'hA5A5);
    send_item(OP_TICK, 16'h0000);
    send_item(OP_CODE, CODE_RED_UP);
  endtask

  // random calls, with runs of plain calls while party mode is on
  task automatic test_random_calls(int count);
    int sent;
    int run;
    int k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(OP_CODE, CODE_PARTY);
        run = $urandom_range(2, 8);
        for (k = 0; k < run; k++) send_item(OP_TICK, 16'($urandom()));
        sent += run + 1;
      end else if ($urandom_range(0, 99) < 15) begin
        send_item(OP_TICK, 16'($urandom()));
        sent++;
      end else begin
        send_item(OP_CODE, pick_code());
        sent++;
      end
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    int k;
    in_valid <= 1'b0;
    @(posedge clk);
    stall_req = 1'b1;
    @(negedge clk);
    for (k = 0; k < 40; k++) send_item(OP_CODE, pick_code());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    party_on = 1'b0;
    grad_on = 1'b0;
    phase = 10'd0;
    sol_bri = BRI_RESET;
    sol_r = 8'd0;
    sol_g = 8'd0;
    sol_b = 8'd0;
    strip_bri = BRI_RESET;

    test_idle_calls();
    test_brightness_wrap();
    test_color_steps();
    test_presets();
    test_unknown_codes();
    test_party_modes();
    test_random_calls(150);
    calm = 1'b1;
    test_random_calls(60);
    test_backpressure();
    calm = 1'b0;
    test_random_calls(60);
    in_valid <= 1'b0;

    // drain, then give stray frames a chance to show up
    while (frames_due.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);

    $display("sent %0d calls, checked %0d frames (%0d party frames), wave phase at %0d",
             items_sent, frames_seen, party_frames, phase);
    $display("covered presets, colour steps, brightness wrap, party and gradient, stalls");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
